// ----- design/brb_pkg.sv -----
// Shared types and constants for the bit-aligned row blit.
`timescale 1ns / 1ps
`default_nettype none
package brb_pkg;

  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 17;
  localparam int unsigned PosW      = 14;

  localparam logic [CfgIndexW-1:0] CfgBitOffset = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgCopyBits  = 2'd1;

  localparam logic [17:0]     MaxRowBits = 18'd65536;
  localparam logic [PosW-1:0] PosMax     = 14'h3fff;
  localparam logic [7:0]      ByteOnes   = 8'hff;
  localparam logic [3:0]      ByteBits   = 4'd8;

  typedef struct packed {
    logic [7:0]      src;
    logic [7:0]      dst;
    logic [7:0]      prev;
    logic [PosW-1:0] pos;
  } brb_item_t;

  typedef struct packed {
    logic [2:0]          bit_offset;
    logic [CfgDataW-1:0] copy_bits;
  } brb_cfg_t;

endpackage
`default_nettype wire

// ----- design/brb_track.sv -----
// Input stage: tracks the byte position and the previous source byte per beat.
`timescale 1ns / 1ps
`default_nettype none
module brb_track (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         src_i,
  input  wire logic [7:0]         dst_i,
  input  wire logic               row_start_i,
  output logic                    item_valid_o,
  input  wire logic               item_ready_i,
  output brb_pkg::brb_item_t      item_o
);

  logic                       valid_q;
  brb_pkg::brb_item_t         item_q, item_d;
  logic [brb_pkg::PosW-1:0]   pos_q, pos_d, pos_cur;
  logic [7:0]                 prev_q;
  logic                       accept;

  assign in_ready_o   = !valid_q || item_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_comb begin
    pos_cur     = row_start_i ? '0 : pos_q;
    pos_d       = (pos_cur < brb_pkg::PosMax) ? pos_cur + 1'b1 : brb_pkg::PosMax;
    item_d.src  = src_i;
    item_d.dst  = dst_i;
    item_d.prev = prev_q;
    item_d.pos  = pos_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= '0;
      prev_q  <= '0;
    end else begin
      if (in_ready_o) valid_q <= in_valid_i;
      if (accept) begin
        pos_q  <= pos_d;
        prev_q <= src_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= item_d;
  end

  a_start_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && row_start_i |=> pos_q == 14'd1)
    else $error("row start did not restart position");

  a_prev_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> prev_q == $past(src_i) && item_q.prev == $past(prev_q))
    else $error("previous source not carried");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !item_ready_i |=> valid_q && $stable(item_q))
    else $error("input stage lost a stalled beat");

endmodule
`default_nettype wire

// ----- design/brb_merge.sv -----
// Merge stage: builds the mask and the shifted source, drives the result register.
`timescale 1ns / 1ps
`default_nettype none
module brb_merge (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire brb_pkg::brb_cfg_t  cfg_i,
  input  wire logic               item_valid_i,
  output logic                    item_ready_o,
  input  wire brb_pkg::brb_item_t item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              out_byte_o,
  output logic                    row_done_o
);

  logic               valid_q;
  logic [7:0]         byte_q, byte_d;
  logic               done_q, done_d;
  logic [17:0]        bits_sat;
  logic [17:0]        total;
  logic [16:0]        base;
  logic signed [18:0] diff;
  logic [3:0]         lo, hi;
  logic               active;
  logic [7:0]         mask;
  logic [15:0]        shifted;
  logic [7:0]         data;

  assign item_ready_o = !valid_q || out_ready_i;
  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign row_done_o   = done_q;

  always_comb begin
    bits_sat = ({1'b0, cfg_i.copy_bits} > brb_pkg::MaxRowBits) ? brb_pkg::MaxRowBits
                                                                : {1'b0, cfg_i.copy_bits};
    total    = bits_sat + {15'd0, cfg_i.bit_offset};
    base     = {item_i.pos, 3'b000};
    diff     = $signed({1'b0, total}) - $signed({2'b00, base});
    lo       = (item_i.pos == '0) ? {1'b0, cfg_i.bit_offset} : 4'd0;
    hi       = (diff > 19'sd8) ? brb_pkg::ByteBits : diff[3:0];
    active   = (bits_sat != '0) && (diff > $signed({15'd0, lo}));
    mask     = active ? ((brb_pkg::ByteOnes >> lo) & (brb_pkg::ByteOnes << (brb_pkg::ByteBits - hi)))
                      : 8'h00;
    shifted  = {8'h00, item_i.prev} << (brb_pkg::ByteBits - {1'b0, cfg_i.bit_offset});
    data     = shifted[7:0] | (item_i.src >> cfg_i.bit_offset);
    byte_d   = (item_i.dst & ~mask) | (data & mask);
    done_d   = active && (diff <= 19'sd8);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (item_ready_o) begin
      valid_q <= item_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_ready_o && item_valid_i) begin
      byte_q <= byte_d;
      done_q <= done_d;
    end
  end

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_ready_i |=> valid_q && $stable(byte_q) && $stable(done_q))
    else $error("result lost while stalled");

  a_zero_copy_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_i && cfg_i.copy_bits == '0 |-> byte_d == item_i.dst && !done_d)
    else $error("zero-length copy touched the destination");

endmodule
`default_nettype wire

// ----- design/bit_aligned_row_blit_top.sv -----
// Top level of the bit-aligned row blit: configuration registers and two stages.
//
// Usage:
//   Slave stream s_axis carries one destination byte and the source byte at
//   the same position per beat; tuser marks the first byte of a row.
//   Master stream m_axis returns the merged byte; tlast flags the last byte
//   the row copy touches.
//   Configuration writes (cfg_valid_i/cfg_ready_o) set bit_offset (index 0)
//   and copy_bits (index 1); cfg_ready_o is always high. Write only while
//   no beat is in flight.
//   Path: each input beat is registered in the position stage, then in the
//   merge stage into the result register. Throughput: one beat per cycle unless stalled.
//   Reset: position and previous source clear, bit_offset = 0, copy_bits = 8,
//   both stages empty.
//   Stall: when m_axis_tready is low the result register holds and the input
//   stage can still take one more beat before s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none
module bit_aligned_row_blit_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [15:0]                   s_axis_tdata,  // src_byte[7:0], dst_byte[15:8]
  input  wire logic                          s_axis_tuser,  // row_start
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [7:0]                         m_axis_tdata,  // out_byte[7:0]
  output logic                               m_axis_tlast,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [brb_pkg::CfgIndexW-1:0] cfg_index_i,
  input  wire logic [brb_pkg::CfgDataW-1:0]  cfg_data_i
);

  brb_pkg::brb_cfg_t  cfg_q;
  brb_pkg::brb_item_t item;
  logic               item_valid;
  logic               item_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_offset <= 3'd0;
      cfg_q.copy_bits  <= 17'd8;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        brb_pkg::CfgBitOffset: cfg_q.bit_offset <= cfg_data_i[2:0];
        brb_pkg::CfgCopyBits:  cfg_q.copy_bits  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  brb_track u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .src_i        (s_axis_tdata[7:0]),
    .dst_i        (s_axis_tdata[15:8]),
    .row_start_i  (s_axis_tuser),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  brb_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .row_done_o   (m_axis_tlast)
  );

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// Stream testbench for the bit-aligned row blit with a scoreboard of merged bytes.
`timescale 1ns / 1ps
module tb;

  localparam logic [brb_pkg::CfgIndexW-1:0] CfgUnused = 2'd3;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainCycles = 4;

  typedef struct packed {
    logic [7:0] src;
    logic [7:0] dst;
    logic       row_start;
  } blit_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       row_done;
  } merged_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [15:0]                   s_axis_tdata = '0;  // src_byte[7:0], dst_byte[15:8]
  logic                          s_axis_tuser = 1'b0;  // row_start
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [7:0]                    m_axis_tdata;  // out_byte[7:0]
  logic                          m_axis_tlast;  // row_done
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [brb_pkg::CfgIndexW-1:0] cfg_index_i = '0;
  logic [brb_pkg::CfgDataW-1:0]  cfg_data_i = '0;

  // predictor state
  logic [2:0]                    exp_offset = 3'd0;
  logic [brb_pkg::CfgDataW-1:0]  exp_copy_bits = 17'd8;
  logic [brb_pkg::PosW-1:0]      exp_pos = '0;
  logic [7:0]                    exp_prev_src = 8'h00;

  blit_beat_t           beat_q[$];
  merged_t              merged_q[$];
  blit_beat_t           next_beat;
  merged_t              got_merge;
  int                   errors = 0;
  int unsigned          cycles = 0;
  int unsigned          results_seen = 0;
  int                   burst_left = 1;
  int                   gap_left = 0;
  int                   rx_mode = 0;
  int                   rx_mode_left = 0;
  int                   hold_left = 0;
  logic                 hold_done = 1'b0;

  bit_aligned_row_blit_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic merged_t blit_merge(blit_beat_t b);
    logic [brb_pkg::PosW-1:0] pos;
    int                       span, total, base, lo, hi;
    logic [15:0]              wide;
    logic [7:0]               mask, data;
    merged_t                  r;
    pos = b.row_start ? '0 : exp_pos;
    if (exp_copy_bits > brb_pkg::MaxRowBits) span = 65536;
    else span = int'(exp_copy_bits);
    total = int'(exp_offset) + span;
    base = int'(pos) * 8;
    lo = int'(exp_offset) - base;
    if (lo < 0) lo = 0;
    hi = total - base;
    if (hi > 8) hi = 8;
    mask = 8'h00;
    r.row_done = 1'b0;
    if (span > 0 && hi > lo) begin
      mask = (brb_pkg::ByteOnes >> lo) & (brb_pkg::ByteOnes << (8 - hi));
      r.row_done = (base + 8 >= total);
    end
    wide = {8'h00, exp_prev_src} << (8 - int'(exp_offset));
    data = wide[7:0] | (b.src >> exp_offset);
    r.out_byte = (b.dst & ~mask) | (data & mask);
    exp_prev_src = b.src;
    exp_pos = (pos < brb_pkg::PosMax) ? pos + 1'b1 : brb_pkg::PosMax;
    return r;
  endfunction

  // register writes as the block sees them
  always @(posedge clk_i) begin
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == brb_pkg::CfgBitOffset) exp_offset = cfg_data_i[2:0];
      else if (cfg_index_i == brb_pkg::CfgCopyBits) exp_copy_bits = cfg_data_i;
    end
  end

  // source side: bursts with gaps, no gaps while the sink holds off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        merged_q.push_back(blit_merge({s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tuser}));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0 && hold_left == 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (beat_q.size() != 0) begin
          next_beat = beat_q.pop_front();
          s_axis_tdata <= {next_beat.dst, next_beat.src};
          s_axis_tuser <= next_beat.row_start;
          s_axis_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= int'($urandom_range(1, 40));
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 5));
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink side: stall pattern plus one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode <= int'($urandom_range(0, 2));
        rx_mode_left <= int'($urandom_range(16, 64));
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && results_seen >= 150) begin
        hold_left <= 80;
        hold_done <= 1'b1;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
      if (merged_q.size() == 0) begin
        $display("%0t: unexpected beat out_byte %02h row_done %0b", $time,
                 m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        got_merge = merged_q.pop_front();
        if (m_axis_tdata !== got_merge.out_byte) begin
          $display("%0t: out_byte expected %02h actual %02h", $time,
                   got_merge.out_byte, m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== got_merge.row_done) begin
          $display("%0t: row_done expected %0b actual %0b", $time,
                   got_merge.row_done, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic wait_idle();
    while (beat_q.size() != 0 || s_axis_tvalid || merged_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [brb_pkg::CfgIndexW-1:0] idx,
                           input logic [brb_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(input logic [2:0] off, input logic [brb_pkg::CfgDataW-1:0] span);
    logic [13:0] junk;
    junk = 14'($urandom);
    wait_idle();
    write_reg(brb_pkg::CfgBitOffset, {junk, off});
    write_reg(brb_pkg::CfgCopyBits, span);
    @(negedge clk_i);
  endtask

  task automatic push_beat(input logic [7:0] src, input logic [7:0] dst, input logic start);
    beat_q.push_back('{src: src, dst: dst, row_start: start});
  endtask

  task automatic push_row(input int n, input logic start);
    for (int i = 0; i < n; i++)
      push_beat(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), start && i == 0);
  endtask

  initial begin
    logic [2:0]                   off;
    logic [brb_pkg::CfgDataW-1:0] span;
    int                           n, len, pick;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: offset 0, one full byte
    push_beat(8'hff, 8'h00, 1'b1);
    push_beat(8'h00, 8'hff, 1'b0);
    push_beat(8'ha5, 8'h5a, 1'b1);
    // span inside the head byte
    set_config(3'd3, 17'd2);
    push_beat(8'hff, 8'h00, 1'b1);
    push_beat(8'hff, 8'h00, 1'b0);
    push_beat(8'h00, 8'hff, 1'b1);
    // nothing copied
    set_config(3'd0, 17'd0);
    push_beat(8'hff, 8'h00, 1'b1);
    push_beat(8'hff, 8'hff, 1'b0);
    push_beat(8'h00, 8'h00, 1'b0);
    // last bit offset, row continuing without a start mark
    set_config(3'd7, 17'd17);
    write_reg(CfgUnused, '1);
    @(negedge clk_i);
    push_row(4, 1'b1);
    push_row(2, 1'b0);
    // stale source byte ahead of a head byte
    set_config(3'd5, 17'd9);
    push_beat(8'hff, 8'h00, 1'b0);
    push_beat(8'h00, 8'hff, 1'b1);
    push_row(2, 1'b0);
    set_config(3'd1, 17'd65536);
    push_row(3, 1'b1);

    // saturated span
    set_config(3'd7, 17'h1ffff);
    push_row(5, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      off = (ph == 0) ? 3'd0 : (ph == 1) ? 3'd7 : 3'($urandom_range(0, 7));
      pick = int'($urandom_range(0, 9));
      if (ph == 2) span = 17'd1;
      else if (pick == 0) span = 17'd0;
      else if (pick == 1) span = 17'd65536;
      else if (pick == 2) span = 17'($urandom_range(65537, 131071));
      else span = 17'($urandom_range(1, 40));
      set_config(off, span);
      n = 0;
      while (n < 56) begin
        if ($urandom_range(0, 9) == 0) begin
          len = int'($urandom_range(1, 4));
          push_row(len, 1'b0);
        end else begin
          len = (int'(off) + int'(span) + 7) / 8 + int'($urandom_range(0, 2));
          if (len > 24) len = int'($urandom_range(8, 24));
          if (len == 0) len = 1;
          push_row(len, 1'b1);
        end
        n += len;
      end
    end

    wait_idle();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
